FILE: hw/rtl/dnssni_pkg.sv
// ----------------------------------------------------------------------------
// dnssni_pkg: shared types and constants
// Parse phases, result item layout and frame limits for the extractor.
// ----------------------------------------------------------------------------
`default_nettype none
package dnssni_pkg;

  localparam int unsigned MaxFrameBytes = 16384;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);

  typedef enum logic [4:0] {
    PhEth, PhIpHdr, PhBadIp, PhIgnore, PhErr, PhUdpHdr, PhDnsLen, PhDnsBody,
    PhDnsQt1, PhDnsQt2, PhDnsDone, PhTcpHdr, PhTcpOpt, PhTlsRec, PhTlsHello,
    PhSidLen, PhCiphHi, PhCiphLo, PhCompLen, PhExtHi, PhExtLo, PhWalkWait,
    PhWalkHdr, PhWalkBody, PhWalkDone
  } phase_e;

  typedef enum logic [1:0] {
    EvNone = 2'd0,
    EvDns  = 2'd1,
    EvTls  = 2'd2
  } event_e;

  // One result item as it travels from the front end to the output stage.
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  name_byte;
    logic [1:0]  event_kind;
    logic [15:0] record_type;
    logic [2:0]  version_code;
    logic        name_valid;
    logic [14:0] name_len;
    logic        frame_error;
    logic        run_end;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dnssni_front.sv
// ----------------------------------------------------------------------------
// dnssni_front: frame byte parser
// Tracks position and phase per byte, produces up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none
module dnssni_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_take_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_last_i,
  output logic                 name_valid_o,
  output dnssni_pkg::result_t  name_item_o,
  output logic                 sum_valid_o,
  output dnssni_pkg::result_t  sum_item_o
);
  import dnssni_pkg::*;

  phase_e      phase_q, phase_d;
  logic [16:0] pos_q, pos_d;
  logic [5:0]  iphl_q, iphl_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d;
  logic [5:0]  tcphl_q, tcphl_d;
  logic [17:0] nfp_q, nfp_d;
  logic [7:0]  lrem_q, lrem_d, ltot_q, ltot_d;
  logic [15:0] qtype_q, qtype_d, hver_q, hver_d;
  logic [17:0] extend_q, extend_d;
  logic [15:0] etype_q, etype_d, elen_q, elen_d, hlen_q, hlen_d;
  logic [14:0] scnt_q, scnt_d;
  logic        ferr_q, ferr_d, fcand_q, fcand_d, fstr_q, fstr_d;
  logic [17:0] sorg_q, sorg_d, sneed_q, sneed_d;

  logic [7:0]  b;
  logic [17:0] pos, l4, pay, body_end, name_end, sni_name_lo;
  logic        in_range, emit, sni_emit;
  logic [7:0]  emit_ch;
  logic        err, vld;
  event_e      ev;
  logic [2:0]  ver;
  logic [15:0] rt;
  logic [14:0] scnt_n;

  assign b   = data_byte_i;
  assign pos = {1'b0, pos_q};
  assign l4  = 18'd14 + 18'(iphl_q);
  assign pay = l4 + 18'(tcphl_q);
  assign in_range = pos_q < 17'(MaxFrameBytes);
  assign body_end = nfp_q + 18'd4 + 18'(elen_q);
  assign sni_name_lo = sorg_q + 18'd9;

  always_comb begin
    phase_d = phase_q; iphl_d = iphl_q; proto_d = proto_q;
    sport_d = sport_q; dport_d = dport_q; tcphl_d = tcphl_q; nfp_d = nfp_q;
    lrem_d = lrem_q; ltot_d = ltot_q; qtype_d = qtype_q; hver_d = hver_q;
    extend_d = extend_q; etype_d = etype_q; elen_d = elen_q; hlen_d = hlen_q;
    ferr_d = ferr_q; fcand_d = fcand_q; fstr_d = fstr_q;
    sorg_d = sorg_q; sneed_d = sneed_q;
    name_end = sorg_q + 18'd9 + {2'b0, hlen_q[15:8], b};
    emit = 1'b0; emit_ch = b;
    sni_emit = (phase_q >= PhWalkWait) && fstr_q && (pos >= sni_name_lo) &&
               (pos < sni_name_lo + 18'(hlen_q));
    if (sni_emit) emit = 1'b1;
    case (phase_q)
      PhEth: begin
        if (pos == 18'd12 && b != 8'h08) phase_d = PhIgnore;
        else if (pos == 18'd13) phase_d = (b == 8'h00) ? PhIpHdr : PhIgnore;
      end
      PhIpHdr: begin
        if (pos == 18'd14) begin
          iphl_d = {b[3:0], 2'b00};
          if ({b[3:0], 2'b00} < 6'd20) phase_d = PhBadIp;
        end else begin
          if (pos == 18'd23) proto_d = b;
          if (pos == l4 - 18'd1) begin
            if (((pos == 18'd23) ? b : proto_q) == 8'd17) phase_d = PhUdpHdr;
            else if (((pos == 18'd23) ? b : proto_q) == 8'd6) phase_d = PhTcpHdr;
            else phase_d = PhIgnore;
          end
        end
      end
      PhUdpHdr: begin
        case (pos - l4)
          18'd0: sport_d = {b, 8'h00};
          18'd1: sport_d = {sport_q[15:8], b};
          18'd2: dport_d = {b, 8'h00};
          18'd3: dport_d = {dport_q[15:8], b};
          18'd19: phase_d = (sport_q == 16'd53 || dport_q == 16'd53) ? PhDnsLen
                                                                     : PhIgnore;
          default: ;
        endcase
      end
      PhDnsLen: begin
        if (b == 8'd0) begin
          phase_d = (ltot_q == 8'd0) ? PhErr : PhDnsQt1;
        end else if (b > 8'd63) begin
          phase_d = PhErr;
        end else begin
          if (ltot_q != 8'd0) begin
            emit = 1'b1; emit_ch = 8'h2e;
          end
          if (ltot_q != 8'd255) ltot_d = ltot_q + 8'd1;
          lrem_d = b;
          phase_d = PhDnsBody;
        end
      end
      PhDnsBody: begin
        emit = 1'b1;
        lrem_d = lrem_q - 8'd1;
        if (lrem_q == 8'd1) phase_d = PhDnsLen;
      end
      PhDnsQt1: begin qtype_d = {b, 8'h00}; phase_d = PhDnsQt2; end
      PhDnsQt2: begin qtype_d = {qtype_q[15:8], b}; phase_d = PhDnsDone; end
      PhTcpHdr: begin
        if (pos - l4 == 18'd12) tcphl_d = {b[7:4], 2'b00};
        else if (pos - l4 == 18'd19) begin
          if (tcphl_q < 6'd20) phase_d = PhIgnore;
          else phase_d = (tcphl_q == 6'd20) ? PhTlsRec : PhTcpOpt;
        end
      end
      PhTcpOpt: if (pos == pay - 18'd1) phase_d = PhTlsRec;
      PhTlsRec: begin
        if (pos == pay && b != 8'd22) phase_d = PhIgnore;
        else if (pos == pay + 18'd5 && b != 8'd1) phase_d = PhIgnore;
        else if (pos == pay + 18'd8) phase_d = PhTlsHello;
      end
      PhTlsHello: begin
        if (pos == pay + 18'd9) hver_d = {b, 8'h00};
        else if (pos == pay + 18'd10) hver_d = {hver_q[15:8], b};
        else if (pos == pay + 18'd42) begin
          nfp_d = pos + 18'd1; phase_d = PhSidLen;
        end
      end
      PhSidLen: if (pos == nfp_q) begin
        nfp_d = pos + 18'd1 + 18'(b); phase_d = PhCiphHi;
      end
      PhCiphHi: if (pos == nfp_q) begin
        elen_d = {b, 8'h00}; phase_d = PhCiphLo;
      end
      PhCiphLo: begin
        elen_d = {elen_q[15:8], b};
        nfp_d = nfp_q + 18'd2 + {2'b0, elen_q[15:8], b};
        phase_d = PhCompLen;
      end
      PhCompLen: if (pos == nfp_q) begin
        nfp_d = pos + 18'd1 + 18'(b); phase_d = PhExtHi;
      end
      PhExtHi: if (pos == nfp_q) begin
        elen_d = {b, 8'h00}; phase_d = PhExtLo;
      end
      PhExtLo: begin
        elen_d = {elen_q[15:8], b};
        nfp_d = pos + 18'd1;
        extend_d = pos + 18'd1 + {2'b0, elen_q[15:8], b};
        phase_d = PhWalkWait;
      end
      PhWalkWait: if (pos == nfp_q) begin
        if (nfp_q + 18'd4 > extend_q) phase_d = PhWalkDone;
        else begin
          etype_d = {b, 8'h00}; phase_d = PhWalkHdr;
        end
      end
      PhWalkHdr: begin
        if (pos == nfp_q + 18'd1) etype_d = {etype_q[15:8], b};
        else if (pos == nfp_q + 18'd2) elen_d = {b, 8'h00};
        else if (pos == nfp_q + 18'd3) begin
          elen_d = {elen_q[15:8], b};
          if (nfp_q + 18'd4 + {2'b0, elen_q[15:8], b} > extend_q) begin
            ferr_d = 1'b1; phase_d = PhWalkDone;
          end else begin
            if (etype_q == 16'd0 && {elen_q[15:8], b} >= 16'd5 && !fcand_q) begin
              fcand_d = 1'b1; sorg_d = nfp_q;
            end
            if ({elen_q[15:8], b} == 16'd0) begin
              nfp_d = nfp_q + 18'd4; phase_d = PhWalkWait;
            end else phase_d = PhWalkBody;
          end
        end
      end
      PhWalkBody: begin
        if (fcand_q && sorg_q == nfp_q) begin
          if (pos == sorg_q + 18'd7) hlen_d = {b, 8'h00};
          else if (pos == sorg_q + 18'd8) begin
            hlen_d = {hlen_q[15:8], b};
            if (name_end <= extend_q) begin
              fstr_d = 1'b1;
              sneed_d = (name_end > body_end) ? name_end : body_end;
            end
          end
        end
        if (pos == body_end - 18'd1) begin
          nfp_d = pos + 18'd1; phase_d = PhWalkWait;
        end
      end
      default: ;
    endcase
    if (!in_range) begin
      emit = 1'b0;
      phase_d = phase_q; iphl_d = iphl_q; proto_d = proto_q;
      sport_d = sport_q; dport_d = dport_q; tcphl_d = tcphl_q; nfp_d = nfp_q;
      lrem_d = lrem_q; ltot_d = ltot_q; qtype_d = qtype_q; hver_d = hver_q;
      extend_d = extend_q; etype_d = etype_q; elen_d = elen_q; hlen_d = hlen_q;
      ferr_d = ferr_q; fcand_d = fcand_q; fstr_d = fstr_q;
      sorg_d = sorg_q; sneed_d = sneed_q;
    end
  end

  assign scnt_n = (emit && scnt_q != 15'h7fff) ? scnt_q + 15'd1 : scnt_q;
  assign pos_d  = in_range ? pos_q + 17'd1 : pos_q;

  // Summary uses the state after this byte was consumed.
  always_comb begin
    err = 1'b0; vld = 1'b0; ev = EvNone; ver = 3'd0; rt = 16'd0;
    if (pos_d >= 17'd34) begin
      case (phase_d)
        PhIpHdr, PhBadIp, PhUdpHdr, PhTcpHdr, PhTlsHello, PhErr, PhDnsLen,
        PhDnsBody, PhDnsQt1, PhDnsQt2: err = 1'b1;
        PhDnsDone: begin
          ev = EvDns; vld = 1'b1; rt = qtype_d;
        end
        PhWalkWait, PhWalkHdr, PhWalkBody, PhWalkDone: begin
          ev = EvTls;
          err = ferr_d;
          if (phase_d == PhWalkWait && {1'b0, pos_d} < nfp_d) err = 1'b1;
          if (phase_d == PhWalkBody &&
              {1'b0, pos_d} < nfp_d + 18'd4 + 18'(elen_d)) err = 1'b1;
          vld = fstr_d && ({1'b0, pos_d} >= sneed_d);
          if (hver_d >= 16'h0301 && hver_d <= 16'h0304) ver = hver_d[2:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    name_item_o = '0;
    name_item_o.name_byte = emit_ch;
    name_valid_o = in_take_i && emit;
    sum_item_o = '0;
    sum_item_o.item_kind    = 1'b1;
    sum_item_o.event_kind   = ev;
    sum_item_o.record_type  = rt;
    sum_item_o.version_code = ver;
    sum_item_o.name_valid   = vld;
    sum_item_o.name_len     = scnt_n;
    sum_item_o.frame_error  = err;
    sum_item_o.run_end      = 1'b1;
    sum_valid_o = in_take_i && frame_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhEth; pos_q <= '0; iphl_q <= '0; proto_q <= '0;
      sport_q <= '0; dport_q <= '0; tcphl_q <= '0; nfp_q <= '0;
      lrem_q <= '0; ltot_q <= '0; qtype_q <= '0; hver_q <= '0;
      extend_q <= '0; etype_q <= '0; elen_q <= '0; hlen_q <= '0;
      scnt_q <= '0; ferr_q <= 1'b0; fcand_q <= 1'b0; fstr_q <= 1'b0;
      sorg_q <= '0; sneed_q <= '0;
    end else if (in_take_i) begin
      if (frame_last_i) begin
        phase_q <= PhEth; pos_q <= '0; iphl_q <= '0; proto_q <= '0;
        sport_q <= '0; dport_q <= '0; tcphl_q <= '0; nfp_q <= '0;
        lrem_q <= '0; ltot_q <= '0; qtype_q <= '0; hver_q <= '0;
        extend_q <= '0; etype_q <= '0; elen_q <= '0; hlen_q <= '0;
        scnt_q <= '0; ferr_q <= 1'b0; fcand_q <= 1'b0; fstr_q <= 1'b0;
        sorg_q <= '0; sneed_q <= '0;
      end else begin
        phase_q <= phase_d; pos_q <= pos_d; iphl_q <= iphl_d; proto_q <= proto_d;
        sport_q <= sport_d; dport_q <= dport_d; tcphl_q <= tcphl_d; nfp_q <= nfp_d;
        lrem_q <= lrem_d; ltot_q <= ltot_d; qtype_q <= qtype_d; hver_q <= hver_d;
        extend_q <= extend_d; etype_q <= etype_d; elen_q <= elen_d; hlen_q <= hlen_d;
        scnt_q <= scnt_n; ferr_q <= ferr_d; fcand_q <= fcand_d; fstr_q <= fstr_d;
        sorg_q <= sorg_d; sneed_q <= sneed_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take_i && frame_last_i) |=> (pos_q == '0 && phase_q == PhEth))
    else $error("frame state not cleared after last byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 17'(MaxFrameBytes))
    else $error("byte position beyond frame limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fstr_q |-> fcand_q))
    else $error("streaming without a server name candidate");

endmodule
`default_nettype wire

FILE: hw/rtl/dnssni_queue.sv
// ----------------------------------------------------------------------------
// dnssni_queue: result queue
// Small FIFO taking up to two results per cycle, handing one per cycle when the reader takes it.
// ----------------------------------------------------------------------------
`default_nettype none
module dnssni_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_a_i,
  input  dnssni_pkg::result_t data_a_i,
  input  logic                wr_b_i,
  input  dnssni_pkg::result_t data_b_i,
  output logic                room_o,
  output logic                rd_valid_o,
  output dnssni_pkg::result_t rd_data_o,
  input  logic                rd_take_i
);
  import dnssni_pkg::*;

  result_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic [QueuePtrW-1:0] wp_b;
  logic [1:0]           nwr;

  assign nwr   = {1'b0, wr_a_i} + {1'b0, wr_b_i};
  assign wp_b  = wr_a_i ? wp_q + QueuePtrW'(1) : wp_q;
  assign cnt_d = cnt_q + (QueuePtrW+1)'(nwr) - (QueuePtrW+1)'(rd_take_i);
  // Accept a byte only when two free slots remain.
  assign room_o     = cnt_q <= (QueuePtrW+1)'(QueueDepth - 2);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_a_i) mem_q[wp_q] <= data_a_i;
    if (wr_b_i) mem_q[wp_b] <= data_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QueuePtrW'(nwr);
      if (rd_take_i) rp_q <= rp_q + QueuePtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_take_i |-> rd_valid_o)
    else $error("read from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_a_i || wr_b_i) |-> room_o)
    else $error("write without room");

endmodule
`default_nettype wire

FILE: hw/rtl/dnssni_back.sv
// ----------------------------------------------------------------------------
// dnssni_back: output stage
// Registers one result, stamps the error total on summaries.
// ----------------------------------------------------------------------------
`default_nettype none
module dnssni_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  dnssni_pkg::result_t q_data_i,
  output logic                q_take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dnssni_pkg::result_t out_data_o,
  output logic [15:0]         error_total_o
);
  import dnssni_pkg::*;

  logic        vld_q;
  result_t     data_q;
  logic [15:0] ecnt_q, tot_q;
  logic        load;

  assign load     = q_valid_i && (!vld_q || !out_stall_i);
  assign q_take_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; ecnt_q <= '0; tot_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        if (q_data_i.item_kind) begin
          if (q_data_i.frame_error && ecnt_q != 16'hffff) begin
            ecnt_q <= ecnt_q + 16'd1;
            tot_q  <= ecnt_q + 16'd1;
          end else begin
            tot_q <= ecnt_q;
          end
        end else begin
          tot_q <= '0;
        end
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= q_data_i;
  end

  assign out_valid_o   = vld_q;
  assign out_data_o    = data_q;
  assign error_total_o = tot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !data_q.item_kind) |-> tot_q == '0)
    else $error("error total on a name byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && data_q.item_kind) |-> tot_q <= ecnt_q)
    else $error("error total ahead of counter");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ecnt_q) <= ecnt_q || !$past(rst_ni))
    else $error("error counter went backward");

endmodule
`default_nettype wire

FILE: hw/rtl/dns_query_and_tls_sni_extractor.sv
// ----------------------------------------------------------------------------
// dns_query_and_tls_sni_extractor: DNS query name and TLS SNI extractor
// Streams the DNS question name or TLS server name of Ethernet frames and
// closes each frame with a summary item.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per transfer (data_byte_i, frame_last_i),
// accepted when in_valid_i is high and in_stall_o is low. Output channel:
// one result per transfer, accepted when out_valid_o is high and
// out_stall_i is low. Each byte gives zero or one name byte, and the last
// byte of a frame is followed by one summary item with run_end_o set.
// Throughput: one byte per cycle as long as the output keeps up; the front
// parser handles each byte as it is taken and the output stage hands one
// result per cycle while out_stall_i is low. A byte that yields both a name
// byte and a summary puts two results in the queue. Each result is queued
// when its byte transfers and is then loaded into the output register that
// drives out_valid_o; output stalls or older queued results hold it back.
// A four-entry queue separates parser and output; the input is stalled
// while fewer than two slots are free, so a stalled receiver backs up into
// the input without losing results. Reset clears the parser, the queue and
// the error counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module dns_query_and_tls_sni_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  name_byte_o,
  output logic [1:0]  event_kind_o,
  output logic [15:0] record_type_o,
  output logic [2:0]  version_code_o,
  output logic        name_valid_o,
  output logic [14:0] name_len_o,
  output logic        frame_error_o,
  output logic [15:0] error_total_o,
  output logic        run_end_o
);
  import dnssni_pkg::*;

  logic    room, take;
  logic    nm_v, sm_v, q_v, q_take;
  result_t nm_d, sm_d, q_d, o_d;

  // Take a byte when the queue can absorb its worst-case two results.
  assign in_stall_o = !room;
  assign take       = in_valid_i && room;

  dnssni_front u_front (
    .clk_i, .rst_ni,
    .in_take_i(take), .data_byte_i, .frame_last_i,
    .name_valid_o(nm_v), .name_item_o(nm_d),
    .sum_valid_o(sm_v), .sum_item_o(sm_d)
  );

  dnssni_queue u_queue (
    .clk_i, .rst_ni,
    .wr_a_i(nm_v), .data_a_i(nm_d),
    .wr_b_i(sm_v), .data_b_i(sm_d),
    .room_o(room),
    .rd_valid_o(q_v), .rd_data_o(q_d), .rd_take_i(q_take)
  );

  dnssni_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_v), .q_data_i(q_d), .q_take_o(q_take),
    .out_valid_o, .out_stall_i, .out_data_o(o_d), .error_total_o
  );

  assign item_kind_o    = o_d.item_kind;
  assign name_byte_o    = o_d.name_byte;
  assign event_kind_o   = o_d.event_kind;
  assign record_type_o  = o_d.record_type;
  assign version_code_o = o_d.version_code;
  assign name_valid_o   = o_d.name_valid;
  assign name_len_o     = o_d.name_len;
  assign frame_error_o  = o_d.frame_error;
  assign run_end_o      = o_d.run_end;

endmodule
`default_nettype wire

FILE: dv/dnssni_checker.sv
// ----------------------------------------------------------------------------
// dnssni_checker: result predictor and comparator for the extractor
// Watches both channels, predicts the name bytes and frame summaries that
// each accepted frame byte causes, and compares every output transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module dnssni_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        item_kind_i,
  input  logic [7:0]  name_byte_i,
  input  logic [1:0]  event_kind_i,
  input  logic [15:0] record_type_i,
  input  logic [2:0]  version_code_i,
  input  logic        name_valid_i,
  input  logic [14:0] name_len_i,
  input  logic        frame_error_i,
  input  logic [15:0] error_total_i,
  input  logic        run_end_i,
  output int          fail_count_o,
  output int          pending_o
);
  import dnssni_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  nbyte;
    logic [1:0]  ev;
    logic [15:0] rtype;
    logic [2:0]  ver;
    logic        nvalid;
    logic [14:0] nlen;
    logic        ferr;
    logic [15:0] etotal;
    logic        rend;
  } outcome_t;

  localparam logic [2:0] FlagErr    = 3'b001;
  localparam logic [2:0] FlagCand   = 3'b010;
  localparam logic [2:0] FlagStream = 3'b100;

  outcome_t    due_q[$];
  phase_e      phase;
  int unsigned pos, ip_len, proto, sport, dport, tcp_len, field_at;
  int unsigned lab_left, lab_count, qtype, hver, ext_end, ext_type, ext_len;
  int unsigned host_len, name_count, sni_at, sni_need;
  logic [2:0]  flags;
  logic [15:0] err_count;

  task automatic clear_frame();
    pos = 0; phase = PhEth; ip_len = 0; proto = 0; sport = 0; dport = 0;
    tcp_len = 0; field_at = 0; lab_left = 0; lab_count = 0; qtype = 0;
    hver = 0; ext_end = 0; ext_type = 0; ext_len = 0; host_len = 0;
    name_count = 0; flags = '0; sni_at = 0; sni_need = 0;
  endtask

  task automatic emit_char(input logic [7:0] ch);
    outcome_t o;
    o = '0;
    o.nbyte = ch;
    due_q.push_back(o);
    if (name_count < 32'h7FFF) name_count++;
  endtask

  // Advance the parser by one frame byte.
  task automatic parse_byte(input logic [7:0] b);
    int unsigned l4, pay, k, body_end, name_end, bv;
    bv  = 32'(b);
    l4  = 14 + ip_len;
    pay = l4 + tcp_len;
    if (phase >= PhWalkWait && (flags & FlagStream) != 0 &&
        pos >= sni_at + 9 && pos < sni_at + 9 + host_len)
      emit_char(b);
    case (phase)
      PhEth: begin
        if (pos == 12 && b != 8'h08) phase = PhIgnore;
        else if (pos == 13) phase = (b == 8'h00) ? PhIpHdr : PhIgnore;
      end
      PhIpHdr: begin
        if (pos == 14) begin
          ip_len = 32'(b[3:0]) * 4;
          if (ip_len < 20) phase = PhBadIp;
        end else begin
          if (pos == 23) proto = bv;
          if (pos == 14 + ip_len - 1) begin
            if (proto == 17) phase = PhUdpHdr;
            else if (proto == 6) phase = PhTcpHdr;
            else phase = PhIgnore;
          end
        end
      end
      PhUdpHdr: begin
        k = pos - l4;
        if (k == 0) sport = bv << 8;
        else if (k == 1) sport |= bv;
        else if (k == 2) dport = bv << 8;
        else if (k == 3) dport |= bv;
        else if (k == 19) phase = (sport == 53 || dport == 53) ? PhDnsLen : PhIgnore;
      end
      PhDnsLen: begin
        if (bv == 0) phase = (lab_count == 0) ? PhErr : PhDnsQt1;
        else if (bv > 63) phase = PhErr;
        else begin
          if (lab_count > 0) emit_char(8'h2E);
          if (lab_count < 255) lab_count++;
          lab_left = bv;
          phase = PhDnsBody;
        end
      end
      PhDnsBody: begin
        emit_char(b);
        lab_left = (lab_left - 1) & 32'hFF;
        if (lab_left == 0) phase = PhDnsLen;
      end
      PhDnsQt1: begin qtype = bv << 8; phase = PhDnsQt2; end
      PhDnsQt2: begin qtype |= bv; phase = PhDnsDone; end
      PhTcpHdr: begin
        k = pos - l4;
        if (k == 12) tcp_len = 32'(b[7:4]) * 4;
        else if (k == 19) begin
          if (tcp_len < 20) phase = PhIgnore;
          else phase = (tcp_len == 20) ? PhTlsRec : PhTcpOpt;
        end
      end
      PhTcpOpt: if (pos == pay - 1) phase = PhTlsRec;
      PhTlsRec: begin
        k = pos - pay;
        if (k == 0 && bv != 22) phase = PhIgnore;
        else if (k == 5 && bv != 1) phase = PhIgnore;
        else if (k == 8) phase = PhTlsHello;
      end
      PhTlsHello: begin
        k = pos - pay;
        if (k == 9) hver = bv << 8;
        else if (k == 10) hver |= bv;
        else if (k == 42) begin field_at = pos + 1; phase = PhSidLen; end
      end
      PhSidLen:
        if (pos == field_at) begin field_at = pos + 1 + bv; phase = PhCiphHi; end
      PhCiphHi:
        if (pos == field_at) begin ext_len = bv << 8; phase = PhCiphLo; end
      PhCiphLo: begin
        ext_len |= bv;
        field_at = field_at + 2 + ext_len;
        phase = PhCompLen;
      end
      PhCompLen:
        if (pos == field_at) begin field_at = pos + 1 + bv; phase = PhExtHi; end
      PhExtHi:
        if (pos == field_at) begin ext_len = bv << 8; phase = PhExtLo; end
      PhExtLo: begin
        ext_len |= bv;
        field_at = pos + 1;
        ext_end = field_at + ext_len;
        phase = PhWalkWait;
      end
      PhWalkWait:
        if (pos == field_at) begin
          if (field_at + 4 > ext_end) phase = PhWalkDone;
          else begin ext_type = bv << 8; phase = PhWalkHdr; end
        end
      PhWalkHdr: begin
        k = pos - field_at;
        if (k == 1) ext_type |= bv;
        else if (k == 2) ext_len = bv << 8;
        else if (k == 3) begin
          ext_len |= bv;
          body_end = field_at + 4 + ext_len;
          if (body_end > ext_end) begin
            flags |= FlagErr;
            phase = PhWalkDone;
          end else begin
            // Only the first server_name extension of at least five bytes is a candidate.
            if (ext_type == 0 && ext_len >= 5 && (flags & FlagCand) == 0) begin
              flags |= FlagCand;
              sni_at = field_at;
            end
            if (ext_len == 0) begin field_at = body_end; phase = PhWalkWait; end
            else phase = PhWalkBody;
          end
        end
      end
      PhWalkBody: begin
        body_end = field_at + 4 + ext_len;
        if ((flags & FlagCand) != 0 && sni_at == field_at) begin
          if (pos == sni_at + 7) host_len = bv << 8;
          else if (pos == sni_at + 8) begin
            host_len |= bv;
            name_end = sni_at + 9 + host_len;
            if (name_end <= ext_end) begin
              flags |= FlagStream;
              sni_need = (name_end > body_end) ? name_end : body_end;
            end
          end
        end
        if (pos == body_end - 1) begin field_at = pos + 1; phase = PhWalkWait; end
      end
      default: ;
    endcase
  endtask

  task automatic close_frame();
    outcome_t o;
    o = '0;
    o.kind = 1'b1;
    o.rend = 1'b1;
    if (pos >= 34) begin
      case (phase)
        PhIpHdr, PhBadIp, PhUdpHdr, PhTcpHdr, PhTlsHello, PhErr, PhDnsLen,
        PhDnsBody, PhDnsQt1, PhDnsQt2:
          o.ferr = 1'b1;
        PhDnsDone: begin
          o.ev = EvDns; o.nvalid = 1'b1; o.rtype = qtype[15:0];
        end
        PhWalkWait, PhWalkHdr, PhWalkBody, PhWalkDone: begin
          o.ev = EvTls;
          o.ferr = (flags & FlagErr) != 0;
          if (phase == PhWalkWait && pos < field_at) o.ferr = 1'b1;
          if (phase == PhWalkBody && pos < field_at + 4 + ext_len) o.ferr = 1'b1;
          o.nvalid = (flags & FlagStream) != 0 && pos >= sni_need;
          if (hver >= 32'h0301 && hver <= 32'h0304) o.ver = 3'(hver - 32'h0300);
        end
        default: ;
      endcase
    end
    if (o.ferr && err_count != 16'hFFFF) err_count++;
    o.nlen = name_count[14:0];
    o.etotal = err_count;
    due_q.push_back(o);
  endtask

  task automatic check_result();
    outcome_t o;
    if (due_q.size() == 0) begin
      $error("unexpected result: kind %0d byte %0h", item_kind_i, name_byte_i);
      fail_count_o++;
      return;
    end
    o = due_q.pop_front();
    if (item_kind_i !== o.kind) begin
      $error("item_kind: expected %0d, got %0d", o.kind, item_kind_i); fail_count_o++;
    end
    if (name_byte_i !== o.nbyte) begin
      $error("name_byte: expected %0h, got %0h", o.nbyte, name_byte_i); fail_count_o++;
    end
    if (event_kind_i !== o.ev) begin
      $error("event_kind: expected %0d, got %0d", o.ev, event_kind_i); fail_count_o++;
    end
    if (record_type_i !== o.rtype) begin
      $error("record_type: expected %0h, got %0h", o.rtype, record_type_i); fail_count_o++;
    end
    if (version_code_i !== o.ver) begin
      $error("version_code: expected %0d, got %0d", o.ver, version_code_i); fail_count_o++;
    end
    if (name_valid_i !== o.nvalid) begin
      $error("name_valid: expected %0d, got %0d", o.nvalid, name_valid_i); fail_count_o++;
    end
    if (name_len_i !== o.nlen) begin
      $error("name_len: expected %0d, got %0d", o.nlen, name_len_i); fail_count_o++;
    end
    if (frame_error_i !== o.ferr) begin
      $error("frame_error: expected %0d, got %0d", o.ferr, frame_error_i); fail_count_o++;
    end
    if (error_total_i !== o.etotal) begin
      $error("error_total: expected %0d, got %0d", o.etotal, error_total_i); fail_count_o++;
    end
    if (run_end_i !== o.rend) begin
      $error("run_end: expected %0d, got %0d", o.rend, run_end_i); fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      err_count = '0;
      due_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (pos < MaxFrameBytes) begin
          parse_byte(data_byte_i);
          pos++;
        end
        if (frame_last_i) begin
          close_frame();
          clear_frame();
        end
      end
      if (out_valid_i && !out_stall_i) check_result();
    end
    pending_o = due_q.size();
  end

endmodule
`default_nettype wire

FILE: dv/tb_dns_query_and_tls_sni_extractor.sv
// ----------------------------------------------------------------------------
// tb_dns_query_and_tls_sni_extractor: frame-level testbench for the extractor
// Builds Ethernet frames carrying DNS queries and TLS ClientHellos, plus
// broken and noise frames, streams them byte by byte with random gaps and
// output stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_dns_query_and_tls_sni_extractor;
  import dnssni_pkg::*;

  localparam int IdlePct    = 21;
  localparam int QuietLimit = 4000;
  localparam int RandBytes  = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        frame_last_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        item_kind_o;
  logic [7:0]  name_byte_o;
  logic [1:0]  event_kind_o;
  logic [15:0] record_type_o;
  logic [2:0]  version_code_o;
  logic        name_valid_o;
  logic [14:0] name_len_o;
  logic        frame_error_o;
  logic [15:0] error_total_o;
  logic        run_end_o;

  int          fail_count;
  int          pending;
  int          quiet;
  int          sent;
  bit          calm;
  logic [7:0]  frame_q[$];

  dns_query_and_tls_sni_extractor dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .frame_last_i,
    .out_valid_o, .out_stall_i, .item_kind_o, .name_byte_o, .event_kind_o,
    .record_type_o, .version_code_o, .name_valid_o, .name_len_o,
    .frame_error_o, .error_total_o, .run_end_o
  );

  dnssni_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .data_byte_i,
    .frame_last_i, .out_valid_i(out_valid_o), .out_stall_i,
    .item_kind_i(item_kind_o), .name_byte_i(name_byte_o),
    .event_kind_i(event_kind_o), .record_type_i(record_type_o),
    .version_code_i(version_code_o), .name_valid_i(name_valid_o),
    .name_len_i(name_len_o), .frame_error_i(frame_error_o),
    .error_total_i(error_total_o), .run_end_i(run_end_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Stall the output at random, except during the calm stretch.
  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < IdlePct);

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("dns_query_and_tls_sni_extractor: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Move one byte across the input channel; hold it until the transfer.
  task automatic put_byte(input logic [7:0] b, input logic fl);
    while (!calm && $urandom_range(99) < IdlePct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    frame_last_i <= fl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) put_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic add_rand(input int n);
    repeat (n) frame_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic add16(input logic [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic eth_hdr(input bit is_ip);
    add_rand(12);
    add16(is_ip ? 16'h0800 : 16'h86DD);
  endtask

  // IPv4 header: protocol sits at frame offset 23.
  task automatic ip_hdr(input int ihl, input logic [7:0] proto);
    frame_q.push_back({4'h4, ihl[3:0]});
    add_rand(8);
    frame_q.push_back(proto);
    add_rand(((ihl >= 5) ? ihl * 4 : 20) - 10);
  endtask

  function automatic int pick_ihl();
    return ($urandom_range(9) == 0) ? $urandom_range(6, 15) : 5;
  endfunction

  // DNS query; the extractor treats 20 bytes after the IP header as UDP+DNS header.
  task automatic dns_frame(input int nlab, input int maxlen, input bit port53);
    int len;
    eth_hdr(1'b1);
    ip_hdr(pick_ihl(), 8'd17);
    if (!port53) begin
      add16(16'd1053); add16(16'd5353);
    end else if ($urandom_range(1)) begin
      add16(16'd53); add16(16'($urandom_range(65535)));
    end else begin
      add16(16'($urandom_range(65535))); add16(16'd53);
    end
    add_rand(16);
    for (int i = 0; i < nlab; i++) begin
      len = $urandom_range(1, maxlen);
      frame_q.push_back(8'(len));
      add_rand(len);
    end
    frame_q.push_back(8'h00);
    add16(($urandom_range(1)) ? 16'h0001 : 16'($urandom_range(65535)));
    add_rand($urandom_range(0, 4));
  endtask

  // TLS ClientHello with an optional filler extension ahead of server_name.
  task automatic tls_frame(input int hlen, input logic [15:0] ver, input bit filler,
                           input bit lie, input bit twice);
    logic [7:0] ext_q[$];
    int doff, sid, ciph, flen;
    doff = ($urandom_range(4) == 0) ? $urandom_range(6, 8) : 5;
    sid  = $urandom_range(0, 8);
    ciph = 2 * $urandom_range(1, 3);
    eth_hdr(1'b1);
    ip_hdr(pick_ihl(), 8'd6);
    add_rand(12);
    frame_q.push_back({doff[3:0], 4'h0});
    add_rand(7 + (doff - 5) * 4);
    frame_q.push_back(8'd22);
    add16(16'h0301);
    add_rand(2);
    frame_q.push_back(8'd1);
    add_rand(3);
    add16(ver);
    add_rand(32);
    frame_q.push_back(8'(sid));
    add_rand(sid);
    add16(16'(ciph));
    add_rand(ciph);
    frame_q.push_back(8'd1);
    frame_q.push_back(8'd0);
    if (filler) begin
      flen = $urandom_range(0, 4);
      ext_q.push_back(8'h00); ext_q.push_back(8'h10);
      // A lying length overruns the extension block.
      ext_q.push_back(8'h00); ext_q.push_back(lie ? 8'hF0 : 8'(flen));
      repeat (flen) ext_q.push_back(8'($urandom_range(255)));
    end
    repeat (twice ? 2 : 1) begin
      ext_q.push_back(8'h00); ext_q.push_back(8'h00);
      ext_q.push_back(8'((hlen + 5) >> 8)); ext_q.push_back(8'((hlen + 5) & 255));
      ext_q.push_back(8'((hlen + 3) >> 8)); ext_q.push_back(8'((hlen + 3) & 255));
      ext_q.push_back(8'h00);
      ext_q.push_back(8'(hlen >> 8)); ext_q.push_back(8'(hlen & 255));
      repeat (hlen) ext_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
    add16(16'(ext_q.size()));
    foreach (ext_q[i]) frame_q.push_back(ext_q[i]);
  endtask

  task automatic noise_frame();
    if ($urandom_range(1)) add_rand($urandom_range(1, 80));
    else begin
      eth_hdr(1'($urandom_range(1)));
      add_rand($urandom_range(1, 60));
    end
  endtask

  initial begin
    int kind;
    logic [15:0] ver;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    frame_last_i = 1'b0;
    quiet        = 0;
    sent         = 0;
    calm         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one-byte and short frames give neither event nor error.
    frame_q.push_back(8'hFF); send_frame();
    add_rand(20); send_frame();
    // Good DNS query, then label over 63, then empty name.
    dns_frame(3, 6, 1'b1); send_frame();
    dns_frame(0, 1, 1'b1); frame_q[54] = 8'd64; send_frame();
    dns_frame(0, 1, 1'b1); send_frame();
    // Non-DNS UDP ports, non-IP ethertype, header length below 20.
    dns_frame(2, 4, 1'b0); send_frame();
    eth_hdr(1'b0); add_rand(40); send_frame();
    eth_hdr(1'b1); ip_hdr(3, 8'd17); add_rand(10); send_frame();
    // Good ClientHellos across the version range, with a second server_name.
    tls_frame(11, 16'h0304, 1'b1, 1'b0, 1'b1); send_frame();
    tls_frame(1, 16'h0300, 1'b0, 1'b0, 1'b0); send_frame();
    tls_frame(4, 16'h0301, 1'b1, 1'b0, 1'b0); send_frame();
    // Overrunning extension, truncated host name, truncated hello.
    tls_frame(6, 16'h0303, 1'b1, 1'b1, 1'b0); send_frame();
    tls_frame(9, 16'h0303, 1'b0, 1'b0, 1'b0);
    repeat (3) frame_q.delete(frame_q.size() - 1);
    send_frame();
    tls_frame(9, 16'h0302, 1'b0, 1'b0, 1'b0);
    while (frame_q.size() > 74) frame_q.delete(frame_q.size() - 1);
    send_frame();

    // Pause until every expected result has come.
    drop_valid();
    while (pending != 0) @(posedge clk_i);

    // Random: mostly well-formed frames with random content, some broken.
    for (int f = 0; sent < RandBytes; f++) begin
      calm = (f < 2);
      kind = $urandom_range(9);
      if (kind < 4) begin
        dns_frame($urandom_range(1, 4), ($urandom_range(7) == 0) ? 63 : 10, 1'b1);
        if ($urandom_range(9) == 0) frame_q[$urandom_range(54, frame_q.size() - 1)]
          = 8'($urandom_range(255));
      end else if (kind < 8) begin
        ver = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                       : 16'h0300 + 16'($urandom_range(5));
        tls_frame($urandom_range(1, 20), ver, 1'($urandom_range(1)),
                  $urandom_range(9) == 0, $urandom_range(5) == 0);
      end else begin
        noise_frame();
      end
      if ($urandom_range(6) == 0)
        while (frame_q.size() > 1 && $urandom_range(15) != 0)
          frame_q.delete(frame_q.size() - 1);
      send_frame();
    end
    calm = 1'b0;

    drop_valid();
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("dns_query_and_tls_sni_extractor: match");
    end else begin
      $display("dns_query_and_tls_sni_extractor: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/dnssni_pkg.sv
hw/rtl/dnssni_front.sv
hw/rtl/dnssni_queue.sv
hw/rtl/dnssni_back.sv
hw/rtl/dns_query_and_tls_sni_extractor.sv
dv/dnssni_checker.sv
dv/tb_dns_query_and_tls_sni_extractor.sv
